// File: hdl/frame_timer_fixed_step_defines.svh
// Assertion macros shared by the frame timer RTL.
`ifndef FRAME_TIMER_FIXED_STEP_DEFINES_SVH
`define FRAME_TIMER_FIXED_STEP_DEFINES_SVH
`ifndef SYNTHESIS
`define FTS_ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define FTS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FTS_ASSERT_IMPL(label, clk, rst, prop, msg)
`define FTS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: hdl/fts_pkg.sv
// ------------------------------------------------------------------------
// fts_pkg: frame timer package
// Shared types and constants of the frame timer.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package fts_pkg;
  localparam logic [30:0] MAX_DELTA_RESET = 31'd100000;
  localparam logic [30:0] FIXED_DELTA_RESET = 31'd16667;
  localparam logic [0:0] REG_MAX_DELTA = 1'b0;
  localparam logic [0:0] REG_FIXED_DELTA = 1'b1;

  typedef struct packed {
    logic [30:0] clamped;
    logic [30:0] delta;
  } fts_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV_STEP, ST_DIV_RATE, ST_DIV_AVG, ST_OUT
  } fts_state_t;
endpackage
`default_nettype wire

// File: hdl/fts_divider.sv
// ------------------------------------------------------------------------
// fts_divider: serial divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module fts_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [32:0] divisor,
  output logic             done,
  output logic [63:0]      quotient,
  output logic [32:0]      remainder
);
  logic [6:0] count;
  logic busy;
  logic [32:0] divisor_q;
  logic [33:0] trial;
  assign trial = {remainder, quotient[63]} - {1'b0, divisor_q};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= 7'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 7'd0;
      end else if (busy) begin
        count <= count + 7'd1;
        if (count == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      remainder <= 33'd0;
      divisor_q <= divisor;
    end else if (busy) begin
      if (!trial[33]) begin
        remainder <= trial[32:0];
        quotient <= {quotient[62:0], 1'b1};
      end else begin
        remainder <= {remainder[31:0], quotient[63]};
        quotient <= {quotient[62:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// File: hdl/fts_front.sv
// ------------------------------------------------------------------------
// fts_front: front end
// Holds configuration, clamps and limits each delta, queues classified items.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module fts_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [31:0]       raw_delta,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [31:0]       cfg_index,
  input  wire logic [31:0]       cfg_data,
  output logic [30:0]            fixed_delta,
  output logic                   q_valid,
  input  wire logic              q_take,
  output fts_pkg::fts_item_t     q_item
);
  logic [30:0] max_delta;
  fts_pkg::fts_item_t slot [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] fill;
  fts_pkg::fts_item_t in_item;
  logic do_push, do_pop;

  assign cfg_ready = 1'b1;
  assign full = fill[1];
  assign q_valid = fill != 2'd0;
  assign q_item = slot[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = q_take && q_valid;
  assign in_item.clamped = raw_delta[31] ? 31'd0 : raw_delta[30:0];
  assign in_item.delta = (in_item.clamped < max_delta) ? in_item.clamped : max_delta;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_delta <= fts_pkg::MAX_DELTA_RESET;
      fixed_delta <= fts_pkg::FIXED_DELTA_RESET;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (cfg_valid && cfg_data[30:0] != 31'd0 && cfg_index[31:1] == 31'd0) begin
        if (cfg_index[0] == fts_pkg::REG_MAX_DELTA) max_delta <= cfg_data[30:0];
        else fixed_delta <= cfg_data[30:0];
      end
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= in_item;
  end
endmodule
`default_nettype wire

// File: hdl/fts_back.sv
// ------------------------------------------------------------------------
// fts_back: back end
// Updates the timer state and runs the three divisions on a shared divider.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module fts_back #(
  parameter int TICKS_PER_SECOND = 1000000
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  output logic               q_take,
  input  wire fts_pkg::fts_item_t q_item,
  input  wire logic [30:0]   fixed_delta,
  output logic               empty,
  input  wire logic          pop,
  output logic [30:0]        clamped_raw_delta,
  output logic [30:0]        frame_delta,
  output logic [63:0]        total_time,
  output logic [63:0]        frame_number,
  output logic [31:0]        fixed_steps_due,
  output logic [30:0]        step_remainder,
  output logic [31:0]        current_rate,
  output logic [31:0]        average_rate
);
  localparam logic [63:0] RATE_NUM = 64'(TICKS_PER_SECOND) * 64'd256;
  localparam logic [32:0] TPS = 33'(TICKS_PER_SECOND);

  fts_pkg::fts_state_t state, state_next;
  logic [63:0] time_sum;
  logic [30:0] step_acc;
  logic [63:0] frame_counter;
  logic [32:0] interval_time;
  logic [31:0] interval_frames;
  logic [31:0] average_latch;
  logic [32:0] int_time_new;
  logic [31:0] int_frames_new;
  logic [30:0] delta;

  logic div_start, div_done;
  logic [63:0] div_dividend, quo;
  logic [32:0] div_divisor, rem;

  fts_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quotient(quo), .remainder(rem)
  );

  assign int_time_new = interval_time + {2'd0, delta};
  assign int_frames_new = interval_frames + 32'd1;

  always_comb begin
    state_next = state;
    case (state)
      fts_pkg::ST_IDLE: if (q_valid) state_next = fts_pkg::ST_DIV_STEP;
      fts_pkg::ST_DIV_STEP: if (div_done) state_next = (delta != 31'd0) ?
        fts_pkg::ST_DIV_RATE : fts_pkg::ST_OUT;
      fts_pkg::ST_DIV_RATE: if (div_done) state_next = (int_time_new >= TPS) ?
        fts_pkg::ST_DIV_AVG : fts_pkg::ST_OUT;
      fts_pkg::ST_DIV_AVG: if (div_done) state_next = fts_pkg::ST_OUT;
      fts_pkg::ST_OUT: if (pop) state_next = fts_pkg::ST_IDLE;
      default: state_next = fts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_take = 1'b0;
    div_start = 1'b0;
    div_dividend = 64'd0;
    div_divisor = 33'd1;
    empty = 1'b1;
    case (state)
      fts_pkg::ST_IDLE: begin
        q_take = q_valid;
        div_start = q_valid;
        div_dividend = 64'(step_acc) + 64'(q_item.delta);
        div_divisor = {2'd0, fixed_delta};
      end
      fts_pkg::ST_DIV_STEP: begin
        div_start = div_done && delta != 31'd0;
        div_dividend = RATE_NUM;
        div_divisor = {2'd0, delta};
      end
      fts_pkg::ST_DIV_RATE: begin
        div_start = div_done && int_time_new >= TPS;
        div_dividend = 64'(int_frames_new) * RATE_NUM;
        div_divisor = int_time_new;
      end
      fts_pkg::ST_OUT: empty = 1'b0;
      default: empty = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fts_pkg::ST_IDLE;
      time_sum <= 64'd0;
      step_acc <= 31'd0;
      frame_counter <= 64'd0;
      interval_time <= 33'd0;
      interval_frames <= 32'd0;
      average_latch <= 32'd0;
    end else begin
      state <= state_next;
      case (state)
        fts_pkg::ST_IDLE: if (q_valid) begin
          time_sum <= time_sum + 64'(q_item.delta);
          frame_counter <= frame_counter + 64'd1;
        end
        fts_pkg::ST_DIV_STEP: if (div_done) step_acc <= rem[30:0];
        fts_pkg::ST_DIV_RATE: if (div_done) begin
          if (int_time_new >= TPS) begin
            interval_time <= 33'd0;
            interval_frames <= 32'd0;
          end else begin
            interval_time <= int_time_new;
            interval_frames <= int_frames_new;
          end
        end
        fts_pkg::ST_DIV_AVG: if (div_done)
          average_latch <= (quo[63:32] != 32'd0) ? 32'hFFFF_FFFF : quo[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      fts_pkg::ST_IDLE: if (q_valid) begin
        delta <= q_item.delta;
        clamped_raw_delta <= q_item.clamped;
        frame_delta <= q_item.delta;
        total_time <= time_sum + 64'(q_item.delta);
        frame_number <= frame_counter + 64'd1;
        current_rate <= 32'd0;
      end
      fts_pkg::ST_DIV_STEP: if (div_done) begin
        fixed_steps_due <= (quo[63:32] != 32'd0) ? 32'hFFFF_FFFF : quo[31:0];
        step_remainder <= rem[30:0];
      end
      fts_pkg::ST_DIV_RATE: if (div_done)
        current_rate <= (quo[63:32] != 32'd0) ? 32'hFFFF_FFFF : quo[31:0];
      default: ;
    endcase
  end

  assign average_rate = average_latch;
endmodule
`default_nettype wire

// File: hdl/frame_timer_fixed_step.sv
// ------------------------------------------------------------------------
// frame_timer_fixed_step: frame timer with fixed-step accumulator
// Top level joining the front end, the item queue and the back end.
// ------------------------------------------------------------------------
// Usage: push a raw frame delta when full is low; one result per item
// appears when empty is low and is taken with pop. Configuration writes
// (index 0 max_delta, 1 fixed_delta) with non-zero data are taken on
// cfg_valid at any time, ready is always high, and should only be made
// while the block is idle. The front end queues up to two items. The
// back end shares one serial divider for the step division, then the
// rate division when the delta is non-zero, then the average division at
// an interval end. The next queued item starts the cycle after the result
// transfer, so the back end takes no new item until the result is popped.
// The result holds until popped; while it waits, the queue keeps filling
// and full rises when two items are held. Synchronous reset clears all
// timer state and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "frame_timer_fixed_step_defines.svh"
module frame_timer_fixed_step #(
  parameter int TICKS_PER_SECOND = 1000000
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] raw_delta,
  output logic             empty,
  input  wire logic        pop,
  output logic [30:0]      clamped_raw_delta,
  output logic [30:0]      frame_delta,
  output logic [63:0]      total_time,
  output logic [63:0]      frame_number,
  output logic [31:0]      fixed_steps_due,
  output logic [30:0]      step_remainder,
  output logic [31:0]      current_rate,
  output logic [31:0]      average_rate,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_index,
  input  wire logic [31:0] cfg_data
);
  logic q_valid, q_take;
  fts_pkg::fts_item_t q_item;
  logic [30:0] fixed_delta;

  fts_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .raw_delta(raw_delta),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fixed_delta(fixed_delta), .q_valid(q_valid),
    .q_take(q_take), .q_item(q_item)
  );

  fts_back #(.TICKS_PER_SECOND(TICKS_PER_SECOND)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
    .fixed_delta(fixed_delta), .empty(empty), .pop(pop),
    .clamped_raw_delta(clamped_raw_delta), .frame_delta(frame_delta),
    .total_time(total_time), .frame_number(frame_number),
    .fixed_steps_due(fixed_steps_due), .step_remainder(step_remainder),
    .current_rate(current_rate), .average_rate(average_rate)
  );

  `FTS_ASSERT_IMPL(a_delta_limited, clk, rst, empty || frame_delta <= clamped_raw_delta, "delta above input")
  `FTS_ASSERT_IMPL(a_rem_below_step, clk, rst, empty || step_remainder < fixed_delta, "remainder too large")
  `FTS_ASSERT_IMPL(a_take_valid, clk, rst, !q_take || q_valid, "queue taken while empty")
  `FTS_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> empty, "result shown after reset")
endmodule
`default_nettype wire
